// File: rtl/cfm_pkg.sv
// Shared constants, types and command/status structs of the cluster factor block.
package cfm_pkg;

  localparam int MaxNodes   = 64;
  localparam int WeightBits = 16;

  localparam int NodeBits   = 6;
  localparam int NodeWidth  = 64;
  localparam int WFieldBits = 16;
  localparam int SumBits    = 32;
  localparam int FracBits   = 16;
  localparam int CfgIdxBits = 1;
  localparam int CfgBits    = 64;
  localparam int FactorBits = FracBits + 1;
  localparam int StatBits   = 2;

  localparam int DenBits     = SumBits + 3;
  localparam int NumBits     = SumBits + FracBits + 1;
  localparam int QuoBits     = FracBits + 1;
  localparam int DivSteps    = QuoBits;
  localparam int DivCntBits  = $clog2(DivSteps);

  localparam logic [NodeWidth-1:0] NodeMask = (MaxNodes >= NodeWidth) ? {NodeWidth{1'b1}} :
    NodeWidth'((65'd1 << MaxNodes) - 65'd1);
  localparam logic [WFieldBits-1:0] WeightMask = (WeightBits >= WFieldBits) ?
    {WFieldBits{1'b1}} : WFieldBits'((33'd1 << WeightBits) - 33'd1);
  localparam logic [FactorBits-1:0] FactorOne = FactorBits'(1 << FracBits);
  localparam logic [SumBits-1:0]    SumMax    = {SumBits{1'b1}};

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgClusterMask = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgPartnerMask = 1'b1;

  typedef enum logic [StatBits-1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_MINUS_ONE  = 2'd2,
    STAT_ZERO_TOTAL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_ACC   = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic setup;
    logic div_step;
    logic load_out;
  } cfm_cmd_t;

  typedef struct packed {
    logic need_div;
  } cfm_sts_t;

endpackage

// File: rtl/cfm_datapath.sv
// Datapath: mask registers, saturating sums, status decode and restoring divider.
module cfm_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfm_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [cfm_pkg::CfgBits-1:0]    cfg_wdata_i,
  input  logic [cfm_pkg::NodeBits-1:0]   row_node_i,
  input  logic [cfm_pkg::NodeBits-1:0]   col_node_i,
  input  logic [cfm_pkg::WFieldBits-1:0] edge_weight_i,
  input  cfm_pkg::cfm_cmd_t              cmd_i,
  output cfm_pkg::cfm_sts_t              sts_o,
  output logic [cfm_pkg::FactorBits-1:0] factor_q16_o,
  output logic [cfm_pkg::StatBits-1:0]   status_o,
  output logic [cfm_pkg::SumBits-1:0]    inner_total_o,
  output logic [cfm_pkg::SumBits-1:0]    partner_total_o,
  output logic [cfm_pkg::SumBits-1:0]    outer_total_o
);
  import cfm_pkg::*;

  logic [NodeWidth-1:0] cmask_q, pmask_q;
  logic [NodeWidth-1:0] cm, pm;
  logic [SumBits-1:0]   inner_q, inner_d, partner_q, partner_d, outer_q, outer_d;
  logic [SumBits-1:0]   res_inner_q, res_partner_q, res_outer_q;
  status_e              stat_q, stat_d;
  logic [DenBits-1:0]   den_q, den_d;
  logic [DenBits-1:0]   rem_q, rem_d;
  logic [QuoBits-1:0]   lo_q, lo_d;
  logic [QuoBits-1:0]   quo_q, quo_d;
  logic [NumBits-1:0]   num;
  logic [DenBits:0]     trial, diff;
  logic [WFieldBits-1:0] w;
  logic                 in_range, counts, col_in, col_pt;
  logic [SumBits:0]     add_sum;
  logic [SumBits-1:0]   add_base, add_sat;
  logic [FactorBits-1:0] factor;
  logic [FactorBits-1:0] out_factor_q;
  status_e              out_stat_q;
  logic [SumBits-1:0]   out_inner_q, out_partner_q, out_outer_q;

  assign cm = cmask_q & NodeMask;
  assign pm = pmask_q & NodeMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmask_q <= '0;
      pmask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClusterMask: cmask_q <= cfg_wdata_i;
        CfgPartnerMask: pmask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // entry classification and one saturating add
  assign w        = edge_weight_i & WeightMask;
  assign in_range = ({1'b0, row_node_i} < (NodeBits+1)'(MaxNodes)) &&
                    ({1'b0, col_node_i} < (NodeBits+1)'(MaxNodes));
  assign counts   = in_range && (w != '0) && cm[row_node_i];
  assign col_in   = cm[col_node_i];
  assign col_pt   = pm[col_node_i];
  assign add_base = col_in ? inner_q : (col_pt ? partner_q : outer_q);
  assign add_sum  = {1'b0, add_base} + (SumBits+1)'(w);
  assign add_sat  = add_sum[SumBits] ? SumMax : add_sum[SumBits-1:0];

  always_comb begin
    inner_d   = inner_q;
    partner_d = partner_q;
    outer_d   = outer_q;
    if (cmd_i.setup) begin
      inner_d   = '0;
      partner_d = '0;
      outer_d   = '0;
    end else if (cmd_i.acc_en && counts) begin
      if (col_in) inner_d = add_sat;
      else if (col_pt) partner_d = add_sat;
      else outer_d = add_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q   <= '0;
      partner_q <= '0;
      outer_q   <= '0;
    end else begin
      inner_q   <= inner_d;
      partner_q <= partner_d;
      outer_q   <= outer_d;
    end
  end

  // status decode, priority: empty, minus one, zero total
  always_comb begin
    if (cm == '0) stat_d = STAT_EMPTY;
    else if (outer_q > partner_q) stat_d = STAT_MINUS_ONE;
    else if (inner_q == '0 && partner_q == '0 && outer_q == '0) stat_d = STAT_ZERO_TOTAL;
    else stat_d = STAT_OK;
  end
  assign sts_o.need_div = (stat_d == STAT_OK);

  // den = inner + 2*partner + outer, num = inner*2^16 + den/2
  always_comb begin
    den_d = DenBits'(inner_q) + DenBits'({partner_q, 1'b0}) + DenBits'(outer_q);
    num   = (NumBits'(inner_q) << FracBits) + NumBits'(den_d >> 1);
  end

  // restoring division, one quotient bit a step; quotient fits QuoBits
  assign trial = {rem_q, lo_q[QuoBits-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    lo_d  = lo_q;
    quo_d = quo_q;
    if (cmd_i.setup) begin
      rem_d = DenBits'(num[NumBits-1:QuoBits]);
      lo_d  = num[QuoBits-1:0];
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      lo_d = {lo_q[QuoBits-2:0], 1'b0};
      if (!diff[DenBits]) begin
        rem_d = diff[DenBits-1:0];
        quo_d = {quo_q[QuoBits-2:0], 1'b1};
      end else begin
        rem_d = trial[DenBits-1:0];
        quo_d = {quo_q[QuoBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    if (cmd_i.setup) begin
      den_q         <= den_d;
      stat_q        <= stat_d;
      res_inner_q   <= inner_q;
      res_partner_q <= partner_q;
      res_outer_q   <= outer_q;
    end
  end

  always_comb begin
    if (stat_q != STAT_OK) factor = '0;
    else if (quo_q > FactorOne) factor = FactorOne;
    else factor = quo_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_factor_q  <= factor;
      out_stat_q    <= stat_q;
      out_inner_q   <= res_inner_q;
      out_partner_q <= res_partner_q;
      out_outer_q   <= res_outer_q;
    end
  end

  assign factor_q16_o    = out_factor_q;
  assign status_o        = out_stat_q;
  assign inner_total_o   = out_inner_q;
  assign partner_total_o = out_partner_q;
  assign outer_total_o   = out_outer_q;

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_factor_q <= FactorOne)
    else $error("factor above one");

  a_status_zero_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && stat_q != STAT_OK |=> out_factor_q == '0)
    else $error("nonzero factor with status code");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.setup |=> inner_q == '0 && partner_q == '0 && outer_q == '0)
    else $error("sums not cleared after result");

endmodule

// File: rtl/cfm_ctrl.sv
// Controller: accumulate / setup / divide / deliver sequencing and output valid.
module cfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              last_entry_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfm_pkg::cfm_cmd_t cmd_o,
  input  cfm_pkg::cfm_sts_t sts_i
);
  import cfm_pkg::*;

  state_e                state_q, state_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic                  ovalid_q, ovalid_d;
  logic                  take;

  assign in_ready_o = (state_q == ST_ACC);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = take;
        if (take && last_entry_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        state_d     = sts_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivCntBits'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.load_out) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_ACC;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  a_last_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last_entry_i |=> state_q == ST_SETUP)
    else $error("last item did not start result");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DIV |-> cnt_q == '0)
    else $error("divide counter active outside divide");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !ovalid_q || out_ready_i)
    else $error("pending result overwritten");

endmodule

// File: rtl/cluster_factor_metric_top.sv
// Top level of the cluster factor block: controller plus datapath.
// Throughput: one matrix item per cycle while summing (in_ready_o high in the sum state).
// Result path: an accepted last item goes through a setup step, then, unless a status short cut
//   applies, 17 steps of the 1-bit-per-cycle restoring divider, then the result load, which waits
//   while an unread result is held. No item is taken from last item until result load.
// Reset (rst_ni, async, active low): masks and sums to zero, no result pending.
module cluster_factor_metric_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [cfm_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [cfm_pkg::CfgBits-1:0]    cfg_wdata_i,
  // matrix entry items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cfm_pkg::NodeBits-1:0]   row_node_i,
  input  logic [cfm_pkg::NodeBits-1:0]   col_node_i,
  input  logic [cfm_pkg::WFieldBits-1:0] edge_weight_i,
  input  logic                           last_entry_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cfm_pkg::FactorBits-1:0] factor_q16_o,
  output logic [cfm_pkg::StatBits-1:0]   status_o,
  output logic [cfm_pkg::SumBits-1:0]    inner_total_o,
  output logic [cfm_pkg::SumBits-1:0]    partner_total_o,
  output logic [cfm_pkg::SumBits-1:0]    outer_total_o
);
  import cfm_pkg::*;

  cfm_cmd_t cmd;
  cfm_sts_t sts;

  // Controller owns the handshakes; the output register holds a finished
  // result while the next matrix is summed.
  cfm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .last_entry_i (last_entry_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Datapath: masks, three saturating sums, status decode, divider, result regs.
  cfm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .row_node_i      (row_node_i),
    .col_node_i      (col_node_i),
    .edge_weight_i   (edge_weight_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .factor_q16_o    (factor_q16_o),
    .status_o        (status_o),
    .inner_total_o   (inner_total_o),
    .partner_total_o (partner_total_o),
    .outer_total_o   (outer_total_o)
  );

endmodule
